@@ hdl/stss_pkg.sv @@
// Shared package for the sorted table search block.
// Sizes, command codes, FSM state and cell link types. No dependencies.
package stss_pkg;

    localparam int DEPTH      = 1024;
    localparam int VALUE_BITS = 16;
    localparam int POS_BITS   = $clog2(DEPTH + 1);
    localparam int CMD_BITS   = 2;

    typedef logic signed [VALUE_BITS-1:0] value_t;
    typedef logic [POS_BITS-1:0]          pos_t;
    typedef logic [CMD_BITS-1:0]          cmd_bits_t;

    typedef enum logic [CMD_BITS-1:0] {
        CMD_CLEAR  = 2'd0,
        CMD_APPEND = 2'd1,
        CMD_SEARCH = 2'd2
    } cmd_t;

    typedef enum logic {
        ST_IDLE,
        ST_RESULT
    } state_t;

    // What one cell hands to its right neighbor.
    typedef struct packed {
        value_t value;
        logic   le;    // valid and value <= broadcast value
        logic   lt;    // valid and value <  broadcast value
    } link_t;

    // Broadcast from the controller to every cell.
    typedef struct packed {
        logic   insert_en;
        logic   search_en;
        value_t key;
    } ctrl_t;

endpackage

@@ hdl/stss_cmd_if.sv @@
// Command channel interface: valid/ready handshake with cmd and value.
// Depends on stss_pkg.
interface stss_cmd_if;
    logic                 valid;
    logic                 ready;
    stss_pkg::cmd_bits_t  cmd;
    stss_pkg::value_t     value;

    modport source (output valid, output cmd, output value, input ready);
    modport sink   (input valid, input cmd, input value, output ready);
endinterface

@@ hdl/stss_res_if.sv @@
// Result channel interface: valid/ready handshake with search/append result.
// Depends on stss_pkg.
interface stss_res_if;
    logic             valid;
    logic             ready;
    logic             found;
    stss_pkg::pos_t   position;
    logic             table_full;
    stss_pkg::pos_t   entry_count;

    modport source (output valid, output found, output position, output table_full,
                    output entry_count, input ready);
    modport sink   (input valid, input found, input position, input table_full,
                    input entry_count, output ready);
endinterface

@@ hdl/stss_cell.sv @@
// One cell of the sorted chain: holds one entry, inserts or shifts on append,
// flags the first matching entry on search. Depends on stss_pkg.
module stss_cell
(
    input  logic            clk,
    input  logic            valid,
    input  stss_pkg::ctrl_t ctrl,
    input  stss_pkg::link_t left,
    output stss_pkg::link_t right,
    output logic            hit
);

    stss_pkg::value_t value_reg;
    stss_pkg::value_t value_next;
    logic             hit_reg;
    logic             hit_next;
    logic             le;
    logic             lt;
    logic             eq;

    assign le = valid && (value_reg <= ctrl.key);
    assign lt = valid && (value_reg <  ctrl.key);
    assign eq = valid && (value_reg == ctrl.key);

    always_comb
    begin
        value_next = value_reg;
        hit_next   = hit_reg;
        if (ctrl.insert_en)
        begin
            if (le)
            begin
                value_next = value_reg;
            end
            else if (left.le)
            begin
                value_next = ctrl.key;
            end
            else
            begin
                value_next = left.value;
            end
        end
        if (ctrl.search_en)
        begin
            // first entry not below the key, and equal to it
            hit_next = eq && left.lt;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
        hit_reg   <= hit_next;
    end

    assign right.value = value_reg;
    assign right.le    = le;
    assign right.lt    = lt;
    assign hit         = hit_reg;

endmodule

@@ hdl/stss_encoder.sv @@
// Encodes the one-hot hit flags of the chain into a one-based position.
// Depends on stss_pkg.
module stss_encoder
(
    input  logic [stss_pkg::DEPTH-1:0] hits,
    output logic                       found,
    output stss_pkg::pos_t             position
);

    always_comb
    begin
        position = '0;
        for (int i = 0; i < stss_pkg::DEPTH; i++)
        begin
            if (hits[i])
            begin
                position = position | stss_pkg::POS_BITS'(i + 1);
            end
        end
    end

    assign found = |hits;

endmodule

@@ hdl/sorted_table_sequential_search.sv @@
// Sorted table with search: a chain of DEPTH cells keeps signed entries in
// ascending order. At the accepting edge the cells insert the value if the
// table has room (shifting larger entries right) or compare against the
// broadcast key; in ST_RESULT the registered hit flags are encoded and the
// result loaded once the output register is free. The next command is
// accepted once the result is loaded, even while it still waits to be taken.
// Depends on stss_pkg, stss_cmd_if, stss_res_if, stss_cell, stss_encoder.
module sorted_table_sequential_search
(
    input  logic       clk,
    input  logic       rst_n,
    stss_cmd_if.sink   cmd_ch,
    stss_res_if.source res_ch
);

    stss_pkg::state_t state_reg;
    stss_pkg::state_t state_next;
    stss_pkg::pos_t   count_reg;
    stss_pkg::pos_t   count_next;
    logic             search_reg;
    logic             search_next;
    logic             full_reg;
    logic             full_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic             out_found_reg;
    stss_pkg::pos_t   out_pos_reg;
    logic             out_full_reg;
    stss_pkg::pos_t   out_count_reg;
    logic             load_out;
    logic             accept;
    logic             has_room;
    stss_pkg::ctrl_t  ctrl;

    stss_pkg::link_t             links [stss_pkg::DEPTH+1];
    logic [stss_pkg::DEPTH-1:0]  hits;
    logic                        enc_found;
    stss_pkg::pos_t              enc_pos;

    assign cmd_ch.ready = (state_reg == stss_pkg::ST_IDLE);
    assign accept       = cmd_ch.valid && cmd_ch.ready;
    assign has_room     = (count_reg < stss_pkg::POS_BITS'(stss_pkg::DEPTH));

    assign ctrl.key       = cmd_ch.value;
    assign ctrl.insert_en = accept && (cmd_ch.cmd == stss_pkg::CMD_APPEND) && has_room;
    assign ctrl.search_en = accept && (cmd_ch.cmd == stss_pkg::CMD_SEARCH);

    // left edge of the chain: always "take the value" and "below the key"
    assign links[0].value = '0;
    assign links[0].le    = 1'b1;
    assign links[0].lt    = 1'b1;

    for (genvar i = 0; i < stss_pkg::DEPTH; i++)
    begin : g_cell
        stss_cell u_cell
        (
            .clk   (clk),
            .valid (stss_pkg::POS_BITS'(i) < count_reg),
            .ctrl  (ctrl),
            .left  (links[i]),
            .right (links[i+1]),
            .hit   (hits[i])
        );
    end

    stss_encoder u_encoder
    (
        .hits     (hits),
        .found    (enc_found),
        .position (enc_pos)
    );

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        search_next    = search_reg;
        full_next      = full_reg;
        out_valid_next = out_valid_reg;
        load_out       = 1'b0;

        if (res_ch.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            stss_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    search_next = 1'b0;
                    full_next   = 1'b0;
                    case (cmd_ch.cmd)
                        stss_pkg::CMD_CLEAR:
                        begin
                            count_next = '0;
                        end
                        stss_pkg::CMD_APPEND:
                        begin
                            if (has_room)
                            begin
                                count_next = count_reg + 1'b1;
                            end
                            else
                            begin
                                full_next = 1'b1;
                            end
                        end
                        stss_pkg::CMD_SEARCH:
                        begin
                            search_next = 1'b1;
                        end
                        default:
                        begin
                            count_next = count_reg;
                        end
                    endcase
                    state_next = stss_pkg::ST_RESULT;
                end
            end
            stss_pkg::ST_RESULT:
            begin
                if (!out_valid_reg || res_ch.ready)
                begin
                    load_out       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = stss_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = stss_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= stss_pkg::ST_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        search_reg <= search_next;
        full_reg   <= full_next;
        if (load_out)
        begin
            out_found_reg <= search_reg && enc_found;
            out_pos_reg   <= search_reg ? enc_pos : '0;
            out_full_reg  <= full_reg;
            out_count_reg <= count_reg;
        end
    end

    assign res_ch.valid       = out_valid_reg;
    assign res_ch.found       = out_found_reg;
    assign res_ch.position    = out_pos_reg;
    assign res_ch.table_full  = out_full_reg;
    assign res_ch.entry_count = out_count_reg;

endmodule

@@ hdl/stss_checker.sv @@
// Port-level checks for sorted_table_sequential_search, attached by bind.
// Depends on stss_pkg.
module stss_checker
(
    input logic           clk,
    input logic           rst_n,
    input logic           in_valid,
    input logic           in_ready,
    input logic           out_valid,
    input logic           out_ready,
    input logic           found,
    input stss_pkg::pos_t position,
    input logic           table_full,
    input stss_pkg::pos_t entry_count
);

    // result holds while stalled
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(position) && $stable(found))
        else $error("result changed while stalled");

    // one item in flight: no accept right after an accept
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("item accepted while previous one in flight");

    a_found_pos: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (found ? (position != '0 && position <= entry_count)
                             : (position == '0)))
        else $error("position inconsistent with found");

    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && table_full |->
            entry_count == stss_pkg::POS_BITS'(stss_pkg::DEPTH) && !found)
        else $error("table_full without a full table");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> entry_count <= stss_pkg::POS_BITS'(stss_pkg::DEPTH))
        else $error("entry_count above depth");

endmodule

bind sorted_table_sequential_search stss_checker u_stss_checker
(
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (cmd_ch.valid),
    .in_ready    (cmd_ch.ready),
    .out_valid   (res_ch.valid),
    .out_ready   (res_ch.ready),
    .found       (res_ch.found),
    .position    (res_ch.position),
    .table_full  (res_ch.table_full),
    .entry_count (res_ch.entry_count)
);
